[rtl/fcgl_pkg.sv]
`default_nettype none
package fcgl_pkg;

  localparam int WINDOW_DEPTH_DEF = 1024;
  localparam int SCALED_W = 48;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STEP   = 2'd1,
    OP_WEIGHT = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_SYSTEM      = 2'd0,
    CFG_MEM_LENGTH  = 2'd1,
    CFG_STEP_SCALE  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    SYS_LORENZ  = 2'd0,
    SYS_ROSSLER = 2'd1,
    SYS_CHEN    = 2'd2
  } system_t;

  localparam logic [1:0]  SYSTEM_RST     = 2'd0;
  localparam logic [9:0]  MEM_LENGTH_RST = 10'd1023;
  localparam logic [31:0] STEP_SCALE_RST = 32'd47081288;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] init_x;
    logic signed [31:0] init_y;
    logic signed [31:0] init_z;
    logic [9:0]         weight_index;
    logic signed [31:0] weight_value;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        step_number;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } state_t;

  typedef struct packed {
    logic signed [SCALED_W-1:0] dx;
    logic signed [SCALED_W-1:0] dy;
    logic signed [SCALED_W-1:0] dz;
  } scaled_t;

endpackage
`default_nettype wire

[rtl/fcgl_ram.sv]
`default_nettype none
module fcgl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = fcgl_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/fcgl_field.sv]
`default_nettype none
module fcgl_field (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [1:0]             sel,
  input  wire logic [31:0]            scale,
  input  wire fcgl_pkg::state_t       st,
  output logic                        done,
  output fcgl_pkg::scaled_t           dvec
);

  typedef struct packed {
    logic signed [33:0] a;
    logic signed [33:0] b;
  } operand_t;

  localparam logic [2:0] OPS_SCALE_LO = 3'd3;
  localparam logic [2:0] OPS_SCALE_HI = 3'd4;

  localparam logic signed [33:0] ONE_Q20   = 34'sd1048576;
  localparam logic signed [33:0] L_SIGMA   = 34'sd10485760;
  localparam logic signed [33:0] L_RHO     = 34'sd29360128;
  localparam logic signed [33:0] L_BETA    = 34'sd2796203;
  localparam logic signed [33:0] R_A       = 34'sd209715;
  localparam logic signed [33:0] R_C       = 34'sd5976883;
  localparam logic signed [33:0] C_A       = 34'sd7864320;
  localparam logic signed [33:0] C_B       = 34'sd2621440;
  localparam logic signed [33:0] C_C       = 34'sd5242880;

  function automatic operand_t term_operands(input logic [1:0] s, input logic [1:0] c,
                                             input logic [2:0] k, input fcgl_pkg::state_t v);
    logic signed [33:0] xs, ys, zs;
    operand_t r;
    xs = 34'(v.x);
    ys = 34'(v.y);
    zs = 34'(v.z);
    r.a = '0;
    r.b = '0;
    case (s)
      fcgl_pkg::SYS_ROSSLER: begin
        case ({c, k})
          5'b00_000: begin r.a = ys + zs; r.b = -ONE_Q20; end
          5'b01_000: begin r.a = xs;      r.b = ONE_Q20;  end
          5'b01_001: begin r.a = ys;      r.b = R_A;      end
          5'b10_000: begin r.a = R_A;     r.b = ONE_Q20;  end
          5'b10_001: begin r.a = zs;      r.b = xs - R_C; end
          default: ;
        endcase
      end
      fcgl_pkg::SYS_CHEN: begin
        case ({c, k})
          5'b00_000: begin r.a = ys - xs; r.b = C_A;      end
          5'b01_000: begin r.a = xs;      r.b = -C_B;     end
          5'b01_001: begin r.a = xs;      r.b = -zs;      end
          5'b01_010: begin r.a = ys;      r.b = C_C;      end
          5'b10_000: begin r.a = xs;      r.b = ys;       end
          5'b10_001: begin r.a = zs;      r.b = -ONE_Q20; end
          default: ;
        endcase
      end
      default: begin
        case ({c, k})
          5'b00_000: begin r.a = ys - xs; r.b = L_SIGMA;  end
          5'b01_000: begin r.a = xs;      r.b = L_RHO;    end
          5'b01_001: begin r.a = ys;      r.b = -ONE_Q20; end
          5'b01_010: begin r.a = xs;      r.b = -zs;      end
          5'b10_000: begin r.a = xs;      r.b = ys;       end
          5'b10_001: begin r.a = zs;      r.b = -L_BETA;  end
          default: ;
        endcase
      end
    endcase
    return r;
  endfunction

  logic                       active;
  logic [1:0]                 comp;
  logic [2:0]                 op;
  logic [1:0]                 phase;
  fcgl_pkg::state_t           st_q;
  logic [1:0]                 sel_q;
  logic [31:0]                scale_q;
  logic signed [33:0]         opa, opb;
  logic signed [67:0]         prod;
  logic signed [67:0]         acc;
  logic [31:0]                plo_hi;

  operand_t                   term;
  operand_t                   opr;
  logic signed [67:0]         mag;
  logic signed [67:0]         asum;
  logic signed [67:0]         rr;
  logic signed [fcgl_pkg::SCALED_W-1:0] rnd;
  logic signed [fcgl_pkg::SCALED_W-1:0] scaled;

  always_comb begin
    mag  = acc[67] ? -acc : acc;
    term = term_operands(sel_q, comp, op, st_q);
    if (op == OPS_SCALE_LO) begin
      opr.a = $signed({2'b00, mag[31:0]});
      opr.b = $signed({2'b00, scale_q});
    end else if (op == OPS_SCALE_HI) begin
      opr.a = $signed({1'b0, mag[64:32]});
      opr.b = $signed({2'b00, scale_q});
    end else begin
      opr = term;
    end
    asum   = prod + $signed({36'd0, plo_hi});
    rr     = (asum + (68'sd1 <<< 19)) >>> 20;
    rnd    = fcgl_pkg::SCALED_W'(rr);
    scaled = acc[67] ? -rnd : rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      comp   <= '0;
      op     <= '0;
      phase  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        comp   <= '0;
        op     <= '0;
        phase  <= '0;
      end else if (active) begin
        case (phase)
          2'd0: phase <= 2'd1;
          2'd1: phase <= 2'd2;
          default: begin
            phase <= 2'd0;
            if (op == OPS_SCALE_HI) begin
              op <= '0;
              if (comp == 2'd2) begin
                active <= 1'b0;
                done   <= 1'b1;
              end else begin
                comp <= comp + 2'd1;
              end
            end else begin
              op <= op + 3'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      st_q    <= st;
      sel_q   <= sel;
      scale_q <= scale;
      acc     <= '0;
    end else if (active) begin
      case (phase)
        2'd0: begin
          opa <= opr.a;
          opb <= opr.b;
        end
        2'd1: prod <= opa * opb;
        default: begin
          if (op == OPS_SCALE_LO) begin
            plo_hi <= prod[63:32];
          end else if (op == OPS_SCALE_HI) begin
            acc <= '0;
            case (comp)
              2'd0:    dvec.dx <= scaled;
              2'd1:    dvec.dy <= scaled;
              default: dvec.dz <= scaled;
            endcase
          end else begin
            acc <= acc + prod;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/fractional_chaos_gl_solver.sv]
`default_nettype none
// Fractional-order Lorenz/Rossler/Chen solver, Grunwald-Letnikov short memory, Q11.20.
// A load or weight write stays in idle; a load returns its result on the next cycle.
// A step first finds where to place the newest entry in the window, then reads
// k = min(step, memory_length) past states one per cycle through the single history
// read port (the vector field runs alongside on one shared multiplier), waits until
// the last products are summed and the vector field is done, then writes back, with
// the result strobe on the cycle after. busy stays high during a step.
// Results come with a one-cycle done strobe and must be taken in that cycle; the
// receiver cannot stall.
module fractional_chaos_gl_solver #(
  parameter int WINDOW_DEPTH = fcgl_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire fcgl_pkg::cmd_t    cmd,
  output logic                   busy,
  output logic                   done,
  output fcgl_pkg::result_t      result,
  input  wire logic              cfg_write,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  localparam int AW  = $clog2(WINDOW_DEPTH);
  localparam int BW  = (AW > 1) ? $clog2(AW) : 1;
  localparam int TW  = 2 * AW + 1;
  localparam int SW  = fcgl_pkg::SCALED_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MOD   = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_WB    = 5'b10000
  } state_e_t;

  state_e_t          state;
  logic [1:0]        sys_sel;
  logic [9:0]        mem_len;
  logic [31:0]       step_scale;
  logic [31:0]       step_count;
  logic [AW-1:0]     write_slot;

  logic [AW-1:0]     m_eff;
  logic [AW:0]       mod_val;
  logic [AW-1:0]     rem;
  logic [AW-1:0]     rem_next;
  logic [TW-1:0]     trial;
  logic [BW-1:0]     div_bit;
  logic [AW-1:0]     base;
  logic [AW-1:0]     rd_ptr;
  logic [AW-1:0]     j;
  logic [AW-1:0]     back;
  logic [AW-1:0]     back_now;
  logic [AW-1:0]     n_last;
  logic [AW-1:0]     slot;

  logic              accept;
  logic              v1, e1, first1, v2;
  logic              fdone_seen;

  logic              h_we;
  logic [AW-1:0]     h_waddr;
  fcgl_pkg::state_t  h_wdata;
  fcgl_pkg::state_t  h_q;
  logic              w_we;
  logic [AW-1:0]     w_waddr;
  logic [31:0]       w_q;

  logic signed [63:0] px, py, pz;
  logic signed [47:0] ax, ay, az;

  logic              fld_done;
  fcgl_pkg::scaled_t dvec;

  fcgl_pkg::state_t  new_st;
  logic [2:0]        sat_v;

  function automatic logic [32:0] clip(input logic signed [SW-1:0] d,
                                       input logic signed [47:0] s);
    logic signed [SW+1:0] v;
    v = (SW+2)'(d) - (SW+2)'(s);
    if (v > (SW+2)'(64'sd2147483647)) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < -(SW+2)'(64'sd2147483648)) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic signed [33:0] round_q50(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + (64'sd1 <<< 29)) >>> 30;
    return t[33:0];
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    logic [32:0] cx, cy, cz;
    m_eff    = (32'(mem_len) > 32'(WINDOW_DEPTH - 1)) ? AW'(WINDOW_DEPTH - 1) : AW'(mem_len);
    mod_val  = {1'b0, m_eff} + (AW+1)'(1);
    trial    = TW'(mod_val) << div_bit;
    rem_next = (TW'(rem) >= trial) ? AW'(TW'(rem) - trial) : rem;
    back_now = (step_count < 32'(m_eff)) ? step_count[AW-1:0] : m_eff;
    slot     = (base == m_eff) ? '0 : base + AW'(1);
    cx       = clip(dvec.dx, ax);
    cy       = clip(dvec.dy, ay);
    cz       = clip(dvec.dz, az);
    new_st.x = $signed(cx[31:0]);
    new_st.y = $signed(cy[31:0]);
    new_st.z = $signed(cz[31:0]);
    sat_v    = {cx[32], cy[32], cz[32]};
    h_we     = (accept && cmd.opcode == fcgl_pkg::OP_LOAD) || (state == S_WB);
    h_waddr  = (state == S_WB) ? slot : '0;
    if (state == S_WB) begin
      h_wdata = new_st;
    end else begin
      h_wdata.x = cmd.init_x;
      h_wdata.y = cmd.init_y;
      h_wdata.z = cmd.init_z;
    end
    w_we    = accept && cmd.opcode == fcgl_pkg::OP_WEIGHT
              && 32'(cmd.weight_index) < 32'(WINDOW_DEPTH);
    w_waddr = AW'(cmd.weight_index);
  end

  fcgl_ram #(.WIDTH($bits(fcgl_pkg::state_t)), .DEPTH(WINDOW_DEPTH)) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (rd_ptr),
    .rdata (h_q)
  );

  fcgl_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_wt (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (cmd.weight_value),
    .raddr (j),
    .rdata (w_q)
  );

  fcgl_field u_field (
    .clk   (clk),
    .rst   (rst),
    .start (v1 && first1),
    .sel   (sys_sel),
    .scale (step_scale),
    .st    (h_q),
    .done  (fld_done),
    .dvec  (dvec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_sel    <= fcgl_pkg::SYSTEM_RST;
      mem_len    <= fcgl_pkg::MEM_LENGTH_RST;
      step_scale <= fcgl_pkg::STEP_SCALE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fcgl_pkg::CFG_SYSTEM:     sys_sel    <= cfg_data[1:0];
        fcgl_pkg::CFG_MEM_LENGTH: mem_len    <= cfg_data[9:0];
        fcgl_pkg::CFG_STEP_SCALE: step_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step_count <= '0;
      write_slot <= '0;
      done       <= 1'b0;
      v1         <= 1'b0;
      e1         <= 1'b0;
      first1     <= 1'b0;
      v2         <= 1'b0;
      fdone_seen <= 1'b0;
    end else begin
      done   <= 1'b0;
      v1     <= (state == S_RUN);
      e1     <= (state == S_RUN) && (j <= back);
      first1 <= (state == S_RUN) && (j == AW'(1));
      v2     <= v1 && e1;
      if (fld_done) begin
        fdone_seen <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && cmd.opcode == fcgl_pkg::OP_LOAD) begin
            step_count <= '0;
            write_slot <= '0;
            done       <= 1'b1;
          end else if (accept && cmd.opcode == fcgl_pkg::OP_STEP) begin
            if (step_count != 32'hFFFF_FFFF) begin
              step_count <= step_count + 32'd1;
            end
            fdone_seen <= 1'b0;
            state      <= S_MOD;
          end
        end
        S_MOD: begin
          if (div_bit == '0) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (j == n_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2 && fdone_seen) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          write_slot <= slot;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      rem     <= write_slot;
      div_bit <= BW'(AW - 1);
      ax      <= '0;
      ay      <= '0;
      az      <= '0;
      if (accept && cmd.opcode == fcgl_pkg::OP_LOAD) begin
        result.step_number <= '0;
        result.out_x       <= cmd.init_x;
        result.out_y       <= cmd.init_y;
        result.out_z       <= cmd.init_z;
        result.saturated   <= 1'b0;
      end
    end
    if (state == S_MOD) begin
      rem     <= rem_next;
      div_bit <= div_bit - BW'(1);
      if (div_bit == '0) begin
        base   <= rem_next;
        rd_ptr <= rem_next;
        j      <= AW'(1);
        back   <= back_now;
        n_last <= (back_now == '0) ? AW'(1) : back_now;
      end
    end
    if (state == S_RUN) begin
      rd_ptr <= (rd_ptr == '0) ? m_eff : rd_ptr - AW'(1);
      j      <= j + AW'(1);
    end
    if (v1) begin
      px <= $signed(w_q) * h_q.x;
      py <= $signed(w_q) * h_q.y;
      pz <= $signed(w_q) * h_q.z;
    end
    if (v2) begin
      ax <= ax + 48'(round_q50(px));
      ay <= ay + 48'(round_q50(py));
      az <= az + 48'(round_q50(pz));
    end
    if (state == S_WB) begin
      result.step_number <= step_count;
      result.out_x       <= new_st.x;
      result.out_y       <= new_st.y;
      result.out_z       <= new_st.z;
      result.saturated   <= |sat_v;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while a step is still in progress");

  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !v1 && !v2)
    else $error("history pipeline busy while idle");

  a_step_start: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == fcgl_pkg::OP_STEP |=> state == S_MOD)
    else $error("step transaction did not start the window search");

  a_field_window: assert property (@(posedge clk) disable iff (rst)
    fld_done |-> state == S_RUN || state == S_DRAIN)
    else $error("vector field finished outside a step");

  a_wb_ready: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> fdone_seen && !v1 && !v2)
    else $error("write back before all terms were summed");

endmodule
`default_nettype wire

[tb/sv/fcgl_checker.sv]
module fcgl_checker
  import fcgl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire cmd_t        cmd,
  input  wire logic        done,
  input  wire result_t     result,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fails,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = WINDOW_DEPTH_DEF;
  localparam longint Q20_ONE = 64'sd1048576;

  logic [1:0]         sys_sel;
  logic [9:0]         mem_len;
  logic [31:0]        scale;
  logic signed [31:0] hist_x [DEPTH];
  logic signed [31:0] hist_y [DEPTH];
  logic signed [31:0] hist_z [DEPTH];
  logic signed [31:0] weights [DEPTH];
  logic [31:0]        step_cnt;
  int                 latest_slot;
  result_t            expected_states [$];

  initial fails = 0;
  initial pending = 0;

  // field * h^alpha, Q.40 x Q0.32 -> Q.20, ties away from zero
  function automatic longint scale_deriv(longint d, logic [31:0] s);
    longint unsigned mag, lo, hi, acc;
    longint r;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    lo = (mag & 64'hFFFF_FFFF) * {32'd0, s};
    hi = (mag >> 32) * {32'd0, s};
    acc = hi + (lo >> 32);
    r = longint'((acc + 64'd524288) >> 20);
    return (d < 0) ? -r : r;
  endfunction

  // Q.50 -> Q.20, ties toward plus infinity
  function automatic longint round_prod(longint p);
    return (p + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [31:0] clip(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic void apply_cmd(cmd_t c);
    result_t r;
    int m, wrap, base, back, idx, j;
    longint x, y, z, w, sx, sy, sz, dx, dy, dz;
    logic sat;
    if (c.opcode == OP_WEIGHT) begin
      weights[c.weight_index] = c.weight_value;
      return;
    end
    if (c.opcode != OP_LOAD && c.opcode != OP_STEP) return;
    sat = 1'b0;
    if (c.opcode == OP_LOAD) begin
      hist_x[0] = c.init_x;
      hist_y[0] = c.init_y;
      hist_z[0] = c.init_z;
      latest_slot = 0;
      step_cnt = '0;
      r.out_x = c.init_x;
      r.out_y = c.init_y;
      r.out_z = c.init_z;
    end else begin
      m = int'(mem_len);
      wrap = m + 1;
      base = latest_slot % wrap;
      if (step_cnt != 32'hFFFF_FFFF) step_cnt = step_cnt + 1;
      back = (step_cnt < m) ? int'(step_cnt) : m;
      sx = 0;
      sy = 0;
      sz = 0;
      for (j = 1; j <= back; j++) begin
        idx = (base + wrap - (j - 1)) % wrap;
        w = weights[j];
        sx += round_prod(w * longint'(hist_x[idx]));
        sy += round_prod(w * longint'(hist_y[idx]));
        sz += round_prod(w * longint'(hist_z[idx]));
      end
      x = hist_x[base];
      y = hist_y[base];
      z = hist_z[base];
      if (sys_sel == SYS_ROSSLER) begin
        dx = -(y + z) * Q20_ONE;
        dy = x * Q20_ONE + 64'sd209715 * y;
        dz = 64'sd209715 * Q20_ONE + z * (x - 64'sd5976883);
      end else if (sys_sel == SYS_CHEN) begin
        dx = 64'sd7864320 * (y - x);
        dy = -64'sd2621440 * x - x * z + 64'sd5242880 * y;
        dz = x * y - Q20_ONE * z;
      end else begin
        dx = 64'sd10485760 * (y - x);
        dy = 64'sd29360128 * x - y * Q20_ONE - x * z;
        dz = x * y - 64'sd2796203 * z;
      end
      r.out_x = clip(scale_deriv(dx, scale) - sx, sat);
      r.out_y = clip(scale_deriv(dy, scale) - sy, sat);
      r.out_z = clip(scale_deriv(dz, scale) - sz, sat);
      latest_slot = (base + 1) % wrap;
      hist_x[latest_slot] = r.out_x;
      hist_y[latest_slot] = r.out_y;
      hist_z[latest_slot] = r.out_z;
    end
    r.step_number = step_cnt;
    r.saturated = sat;
    expected_states.push_back(r);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      sys_sel = SYSTEM_RST;
      mem_len = MEM_LENGTH_RST;
      scale = STEP_SCALE_RST;
      step_cnt = '0;
      latest_slot = 0;
      expected_states.delete();
    end else begin
      if (done) begin
        if (expected_states.size() == 0) begin
          report("unexpected result, step_number", result.step_number, '0);
        end else begin
          e = expected_states.pop_front();
          if (result.step_number !== e.step_number)
            report("step_number", result.step_number, e.step_number);
          if (result.out_x !== e.out_x) report("out_x", result.out_x, e.out_x);
          if (result.out_y !== e.out_y) report("out_y", result.out_y, e.out_y);
          if (result.out_z !== e.out_z) report("out_z", result.out_z, e.out_z);
          if (result.saturated !== e.saturated)
            report("saturated", 32'(result.saturated), 32'(e.saturated));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_SYSTEM:     sys_sel = cfg_data[1:0];
          CFG_MEM_LENGTH: mem_len = cfg_data[9:0];
          CFG_STEP_SCALE: scale = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) apply_cmd(cmd);
    end
    pending = expected_states.size();
  end

endmodule

[tb/sv/tb_fractional_chaos_gl_solver.sv]
module tb_fractional_chaos_gl_solver;
  import fcgl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = WINDOW_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] SYS_UNUSED = 2'd3;
  localparam int STEP_OK = 0;
  localparam int NEED_WEIGHT = 1;
  localparam int NEED_LOAD = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  cmd_t        cmd = '0;
  logic        busy;
  logic        done;
  result_t     result;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fails;
  int          pending;
  int          cycles = 0;

  // stimulus-side view of what has been written, to stay off unwritten entries
  bit          weight_set [DEPTH];
  bit          hist_set [DEPTH];
  int          weight_prefix = 0;
  int          cur_slot = 0;
  int          steps_since_load = 0;
  int          cur_mem_len = int'(MEM_LENGTH_RST);
  bit          idle_on = 1'b1;

  fractional_chaos_gl_solver dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fcgl_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fails(fails), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic cmd_t mk(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [9:0] idx, logic [31:0] val);
    cmd_t c;
    c.opcode = op;
    c.init_x = x;
    c.init_y = y;
    c.init_z = z;
    c.weight_index = idx;
    c.weight_value = val;
    return c;
  endfunction

  function automatic logic [31:0] small_state();
    return 32'(int'($urandom_range(0, 32 << 20)) - (16 << 20));
  endfunction

  function automatic logic [31:0] small_weight();
    return 32'(int'($urandom_range(0, 1 << 28)) - (1 << 27));
  endfunction

  function automatic int step_check();
    int wrap, base, back, j;
    wrap = cur_mem_len + 1;
    base = cur_slot % wrap;
    if (!hist_set[base]) return NEED_LOAD;
    back = (steps_since_load + 1 < cur_mem_len) ? steps_since_load + 1 : cur_mem_len;
    for (j = 1; j <= back; j++)
      if (!hist_set[(base + wrap - (j - 1)) % wrap]) return NEED_LOAD;
    for (j = 1; j <= back; j++)
      if (!weight_set[j]) return NEED_WEIGHT;
    return STEP_OK;
  endfunction

  function automatic void track(cmd_t c);
    int wrap;
    if (c.opcode == OP_LOAD) begin
      hist_set[0] = 1'b1;
      cur_slot = 0;
      steps_since_load = 0;
    end else if (c.opcode == OP_STEP) begin
      wrap = cur_mem_len + 1;
      cur_slot = (cur_slot % wrap + 1) % wrap;
      hist_set[cur_slot] = 1'b1;
      steps_since_load++;
    end else if (c.opcode == OP_WEIGHT) begin
      weight_set[c.weight_index] = 1'b1;
      while (weight_prefix < DEPTH - 1 && weight_set[weight_prefix + 1]) weight_prefix++;
    end
  endfunction

  task automatic send(cmd_t c);
    while (idle_on && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    track(c);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_MEM_LENGTH) cur_mem_len = int'(val[9:0]);
  endtask

  task automatic rand_item();
    cmd_t c;
    int r;
    int blk;
    c = mk(OP_STEP, $urandom, $urandom, $urandom, 10'($urandom), $urandom);
    r = $urandom_range(0, 99);
    if (r < 7) begin
      c.opcode = OP_LOAD;
      if ($urandom_range(0, 3) != 0) begin
        c.init_x = small_state();
        c.init_y = small_state();
        c.init_z = small_state();
      end
    end else if (r < 25) begin
      c.opcode = OP_WEIGHT;
      if (weight_prefix < DEPTH - 1 && $urandom_range(0, 3) != 0)
        c.weight_index = 10'(weight_prefix + 1);
      if ($urandom_range(0, 3) != 0) c.weight_value = small_weight();
    end else if (r < 28) begin
      c.opcode = OP_UNUSED;
    end else begin
      blk = step_check();
      if (blk == NEED_WEIGHT) begin
        c.opcode = OP_WEIGHT;
        c.weight_index = 10'(weight_prefix + 1);
        c.weight_value = small_weight();
      end else if (blk == NEED_LOAD) begin
        c.opcode = OP_LOAD;
        c.init_x = small_state();
        c.init_y = small_state();
        c.init_z = small_state();
      end
    end
    send(c);
  endtask

  initial begin
    logic [1:0]  sel;
    logic [9:0]  mlen;
    logic [31:0] scl;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(mk(OP_WEIGHT, 0, 0, 0, 10'd0, 32'h7FFF_FFFF));
    send(mk(OP_WEIGHT, 0, 0, 0, 10'd1, 32'h8000_0000));
    send(mk(OP_WEIGHT, 0, 0, 0, 10'd2, 32'h7FFF_FFFF));
    send(mk(OP_WEIGHT, 0, 0, 0, 10'd1023, 32'h0000_3039));
    send(mk(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 10'd0, 0));
    send(mk(OP_STEP, 0, 0, 0, 10'd0, 0));
    send(mk(OP_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF));
    send(mk(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, 0));
    send(mk(OP_STEP, 0, 0, 0, 10'd0, 0));
    send(mk(OP_LOAD, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 10'd0, 0));
    send(mk(OP_WEIGHT, 0, 0, 0, 10'd1, 32'hF000_0000));
    send(mk(OP_WEIGHT, 0, 0, 0, 10'd2, 32'h0400_0000));
    send(mk(OP_STEP, 0, 0, 0, 10'd0, 0));
    send(mk(OP_STEP, 0, 0, 0, 10'd0, 0));
    send(mk(OP_UNUSED, 32'h7FFF_FFFF, 0, 0, 10'd5, 32'h1234_5678));
    send(mk(OP_LOAD, 0, 0, 0, 10'd0, 0));
    send(mk(OP_STEP, 0, 0, 0, 10'd0, 0));
    repeat (60) rand_item();

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin sel = SYS_ROSSLER; mlen = 10'd1; scl = 32'hFFFF_FFFF; end
        1: begin sel = SYS_CHEN; mlen = 10'd0; scl = 32'h0; end
        2: begin sel = SYS_UNUSED; mlen = 10'd1023; scl = $urandom; end
        3: begin
          sel = SYS_LORENZ;
          mlen = 10'($urandom_range(2, 40));
          scl = STEP_SCALE_RST;
        end
        4: begin
          sel = 2'($urandom_range(0, 3));
          mlen = 10'($urandom_range(1, 1023));
          scl = $urandom;
        end
        default: begin sel = SYS_CHEN; mlen = 10'd1023; scl = 32'd1; end
      endcase
      write_reg(CFG_SYSTEM, {30'($urandom), sel});
      write_reg(CFG_MEM_LENGTH, {22'($urandom), mlen});
      write_reg(CFG_STEP_SCALE, scl);
      idle_on = (p != 2);
      repeat (85) rand_item();
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
